// ===== rtl/core/fpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Framed packet checker package
// Shared constants, codes and types for the framed packet checker.
// ----------------------------------------------------------------------------
package fpc_pkg;

  // Field widths.
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned LEN_W    = 31;
  localparam int unsigned SUM_W    = 28;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_CONN = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN = 2'd1;

  // Configuration reset values.
  localparam logic [WORD_W-1:0] MAGIC_RESET  = 32'h5891_5851;
  localparam logic [LEN_W-1:0]  MAXLEN_RESET = 31'd15728639;
  localparam logic [LEN_W-1:0]  MIN_LENGTH   = 31'd8;

  // Parser phases.
  localparam logic [1:0] PH_MAGIC   = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_MAGIC    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_LENGTH   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SUM_MISMATCH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SEQ_MISMATCH = 3'd4;

  typedef struct packed {
    logic [WORD_W-1:0] magic_word;
    logic [LEN_W-1:0]  max_length;
  } fpc_cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   packet_id;
    logic [WORD_W-1:0]   expected_id;
    logic [SUM_W-1:0]    computed_sum;
    logic [WORD_W-1:0]   received_sum;
  } fpc_result_t;

endpackage

// ===== rtl/core/fpc_channels.sv =====
// ----------------------------------------------------------------------------
// Framed packet checker channels
// Valid/ready interfaces for the byte input, result output and config write.
// ----------------------------------------------------------------------------
interface fpc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data;

  modport source (output valid, output kind, output data, input ready);
  modport sink   (input valid, input kind, input data, output ready);
endinterface

interface fpc_out_if
  import fpc_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   packet_id;
  logic [WORD_W-1:0]   expected_id;
  logic [SUM_W-1:0]    computed_sum;
  logic [WORD_W-1:0]   received_sum;

  modport source (output valid, output status, output packet_id, output expected_id,
                  output computed_sum, output received_sum, input ready);
  modport sink   (input valid, input status, input packet_id, input expected_id,
                  input computed_sum, input received_sum, output ready);
endinterface

interface fpc_cfg_if
  import fpc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/fpc_in_stage.sv =====
// ----------------------------------------------------------------------------
// Framed packet checker input stage
// Registers one input item and releases it when the parser steps.
// ----------------------------------------------------------------------------
module fpc_in_stage
  import fpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       in_kind_i,
  input  logic [7:0] in_data_i,
  input  logic       step_i,
  output logic       item_valid_o,
  output logic       item_kind_o,
  output logic [7:0] item_data_o
);

  logic       valid_q, valid_d;
  logic       kind_q;
  logic [7:0] data_q;
  logic       load;

  // The register frees up in the same cycle its item is consumed.
  assign in_ready_o = !valid_q || step_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (step_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= in_kind_i;
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_kind_o  = kind_q;
  assign item_data_o  = data_q;

endmodule

// ===== rtl/core/fpc_frame_core.sv =====
// ----------------------------------------------------------------------------
// Framed packet checker frame parser
// Per-byte frame state update and result generation.
// ----------------------------------------------------------------------------
module fpc_frame_core
  import fpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fpc_cfg_t    cfg_i,
  input  logic        step_i,
  input  logic        kind_i,
  input  logic [7:0]  data_i,
  output logic        res_valid_o,
  output fpc_result_t res_o
);

  logic [1:0]        phase_q, phase_d;
  logic [1:0]        hdr_idx_q, hdr_idx_d;
  logic [WORD_W-1:0] magic_q, magic_d;
  logic [WORD_W-1:0] len_q, len_d;
  logic [LEN_W-1:0]  remain_q, remain_d;
  logic [2:0]        id_cnt_q, id_cnt_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [WORD_W-1:0] id_q, id_d;
  logic [WORD_W-1:0] trailer_q, trailer_d;
  logic [WORD_W-1:0] good_q, good_d;
  logic              halted_q, halted_d;

  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    magic_d   = magic_q;
    len_d     = len_q;
    remain_d  = remain_q;
    id_cnt_d  = id_cnt_q;
    sum_d     = sum_q;
    id_d      = id_q;
    trailer_d = trailer_q;
    good_d    = good_q;
    halted_d  = halted_q;

    res_valid_o        = 1'b0;
    res_o.status       = ST_OK;
    res_o.packet_id    = '0;
    res_o.expected_id  = good_q;
    res_o.computed_sum = '0;
    res_o.received_sum = '0;

    if (step_i) begin
      if (kind_i == KIND_CONN) begin
        good_d    = '0;
        halted_d  = 1'b0;
        phase_d   = PH_MAGIC;
        hdr_idx_d = '0;
      end else if (!halted_q) begin
        unique case (phase_q)
          PH_MAGIC: begin
            magic_d   = {data_i, magic_q[WORD_W-1:8]};
            hdr_idx_d = hdr_idx_q + 2'd1;
            if (hdr_idx_q == 2'd3) begin
              if (magic_d != cfg_i.magic_word) begin
                halted_d     = 1'b1;
                res_valid_o  = 1'b1;
                res_o.status = ST_BAD_MAGIC;
              end else begin
                phase_d = PH_LENGTH;
              end
            end
          end
          PH_LENGTH: begin
            len_d     = {data_i, len_q[WORD_W-1:8]};
            hdr_idx_d = hdr_idx_q + 2'd1;
            if (hdr_idx_q == 2'd3) begin
              if (len_d[WORD_W-1] || (len_d[LEN_W-1:0] < MIN_LENGTH) ||
                  (len_d[LEN_W-1:0] > cfg_i.max_length)) begin
                halted_d     = 1'b1;
                res_valid_o  = 1'b1;
                res_o.status = ST_BAD_LENGTH;
              end else begin
                phase_d   = PH_PAYLOAD;
                remain_d  = len_d[LEN_W-1:0] - 31'd1;
                id_cnt_d  = '0;
                sum_d     = '0;
                id_d      = '0;
                trailer_d = '0;
              end
            end
          end
          PH_PAYLOAD: begin
            // The first four payload bytes form the sequence id.
            if (id_cnt_q != 3'd4) begin
              id_d     = {data_i, id_q[WORD_W-1:8]};
              id_cnt_d = id_cnt_q + 3'd1;
            end
            // Everything but the last four bytes is summed.
            if (remain_q >= 31'd4) begin
              sum_d = sum_q + {{(SUM_W-8){1'b0}}, data_i};
            end else begin
              trailer_d = {data_i, trailer_q[WORD_W-1:8]};
            end
            if (remain_q == '0) begin
              res_valid_o        = 1'b1;
              res_o.packet_id    = id_d;
              res_o.computed_sum = sum_q;
              res_o.received_sum = trailer_d;
              if (trailer_d != {{(WORD_W-SUM_W){1'b0}}, sum_q}) begin
                res_o.status = ST_SUM_MISMATCH;
              end else if (id_d != good_q) begin
                res_o.status = ST_SEQ_MISMATCH;
              end else begin
                res_o.status = ST_OK;
              end
              if (res_o.status == ST_OK) begin
                good_d = good_q + 32'd1;
              end else begin
                halted_d = 1'b1;
              end
              phase_d   = PH_MAGIC;
              hdr_idx_d = '0;
            end else begin
              remain_d = remain_q - 31'd1;
            end
          end
          default: begin
            phase_d   = PH_MAGIC;
            hdr_idx_d = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MAGIC;
      hdr_idx_q <= '0;
      magic_q   <= '0;
      len_q     <= '0;
      remain_q  <= '0;
      id_cnt_q  <= '0;
      sum_q     <= '0;
      id_q      <= '0;
      trailer_q <= '0;
      good_q    <= '0;
      halted_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      magic_q   <= magic_d;
      len_q     <= len_d;
      remain_q  <= remain_d;
      id_cnt_q  <= id_cnt_d;
      sum_q     <= sum_d;
      id_q      <= id_d;
      trailer_q <= trailer_d;
      good_q    <= good_d;
      halted_q  <= halted_d;
    end
  end

endmodule

// ===== rtl/core/fpc_out_stage.sv =====
// ----------------------------------------------------------------------------
// Framed packet checker output stage
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module fpc_out_stage
  import fpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  fpc_result_t res_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output fpc_result_t out_res_o
);

  logic        valid_q, valid_d;
  fpc_result_t res_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

// ===== rtl/core/framed_packet_checker.sv =====
// ----------------------------------------------------------------------------
// Framed packet checker
// Checks magic, length, checksum and sequence id of framed byte streams.
// ----------------------------------------------------------------------------
// The checker takes one byte per transfer and sustains one transfer per clock
// cycle unless a result waits untaken in the output register; each byte is
// registered in the input register, and its result, if it makes one, goes
// into the output register as the byte is parsed. Each frame is a four-byte
// start word, a four-byte little-endian payload length and the payload; the
// payload opens with a little-endian sequence id and closes with a
// little-endian checksum word that must equal the 28-bit byte sum of the rest
// of the payload. One result leaves per finished frame or per detected error
// (bad start word, bad length, checksum mismatch, then sequence mismatch).
// After an error the checker drops stream bytes until a connection-start
// transfer, which also clears the expected sequence id. Configuration writes
// (index 0 start word, index 1 maximum length) must only be made while idle;
// the write channel is always ready and writes to other indexes are dropped.
// The input side only stalls while a finished result waits on the output.
module framed_packet_checker
  import fpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  fpc_in_if.sink    in_i,
  fpc_out_if.source out_o,
  fpc_cfg_if.sink   cfg_i
);

  fpc_cfg_t    cfg_q, cfg_d;
  logic        item_valid;
  logic        item_kind;
  logic [7:0]  item_data;
  logic        out_free;
  logic        step;
  logic        res_valid;
  fpc_result_t res;
  fpc_result_t out_res;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MAGIC:  cfg_d.magic_word = cfg_i.wdata;
        CFG_MAXLEN: cfg_d.max_length = cfg_i.wdata[LEN_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word <= MAGIC_RESET;
      cfg_q.max_length <= MAXLEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // A registered item is processed whenever the output register can take a
  // result in the same cycle, so the parser never produces a result that
  // has nowhere to go.
  assign step = item_valid && out_free;

  fpc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_kind_i    (in_i.kind),
    .in_data_i    (in_i.data),
    .step_i       (step),
    .item_valid_o (item_valid),
    .item_kind_o  (item_kind),
    .item_data_o  (item_data)
  );

  fpc_frame_core u_frame_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .step_i      (step),
    .kind_i      (item_kind),
    .data_i      (item_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fpc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (out_res)
  );

  assign out_o.status       = out_res.status;
  assign out_o.packet_id    = out_res.packet_id;
  assign out_o.expected_id  = out_res.expected_id;
  assign out_o.computed_sum = out_res.computed_sum;
  assign out_o.received_sum = out_res.received_sum;

endmodule
